### src/ocb_pkg.sv
// Package: shared constants, types and tables for the orbit camera basis block.
package ocb_pkg;

    localparam int AngleBits    = 16;
    localparam int UnitFracBits = 14;
    localparam int DistFracBits = 8;

    localparam int CordicSteps = 28;
    localparam int CordicFrac  = 30;
    localparam int StepBits    = 5;
    localparam logic signed [33:0] CordicGainInv = 34'sd652032874;

    // Elevation limit: quarter turn less 0.01 rad in angle counts
    localparam longint ElevMargin =
        ((longint'(1) << AngleBits) * 64'd15915494 + 64'd5000000000) / 64'd10000000000;
    localparam longint ElevLimit = (longint'(1) << (AngleBits - 2)) - ElevMargin;

    localparam int UnitOne = 1 << UnitFracBits;

    // Register indexes
    localparam logic [2:0] RegTargetX = 3'd0;
    localparam logic [2:0] RegTargetY = 3'd1;
    localparam logic [2:0] RegTargetZ = 3'd2;
    localparam logic [2:0] RegMinDist = 3'd3;
    localparam logic [2:0] RegMaxDist = 3'd4;

    localparam logic [17:0] MinDistReset = 18'd26;
    localparam logic [17:0] MaxDistReset = 18'd256000;
    localparam logic [17:0] DistReset    = 18'd2560;

    typedef struct packed {
        logic [15:0] delta_azimuth;
        logic [15:0] delta_elevation;
        logic [18:0] zoom_delta;
        logic        load_distance;
        logic [17:0] new_distance;
    } in_item_t;

    typedef struct packed {
        logic [24:0] position_x;
        logic [24:0] position_y;
        logic [24:0] position_z;
        logic [15:0] forward_x;
        logic [15:0] forward_y;
        logic [15:0] forward_z;
        logic [15:0] right_x;
        logic [15:0] right_y;
        logic [15:0] right_z;
        logic [15:0] up_x;
        logic [15:0] up_y;
        logic [15:0] up_z;
    } out_item_t;

    // Start/done handshake between the sequencer and the CORDIC unit
    typedef struct packed {
        logic                 start;
        logic [AngleBits-1:0] angle;
    } cordic_req_t;

    typedef struct packed {
        logic                        done;
        logic signed [UnitFracBits+1:0] cos_v;
        logic signed [UnitFracBits+1:0] sin_v;
    } cordic_rsp_t;

    function automatic logic [31:0] atan_entry(input logic [StepBits-1:0] i);
        logic [31:0] r;
        begin
            case (i)
                5'd0:  r = 32'd536870912;
                5'd1:  r = 32'd316933406;
                5'd2:  r = 32'd167458907;
                5'd3:  r = 32'd85004756;
                5'd4:  r = 32'd42667331;
                5'd5:  r = 32'd21354465;
                5'd6:  r = 32'd10679838;
                5'd7:  r = 32'd5340245;
                5'd8:  r = 32'd2670163;
                5'd9:  r = 32'd1335087;
                5'd10: r = 32'd667544;
                5'd11: r = 32'd333772;
                5'd12: r = 32'd166886;
                5'd13: r = 32'd83443;
                5'd14: r = 32'd41722;
                5'd15: r = 32'd20861;
                5'd16: r = 32'd10430;
                5'd17: r = 32'd5215;
                5'd18: r = 32'd2608;
                5'd19: r = 32'd1304;
                5'd20: r = 32'd652;
                5'd21: r = 32'd326;
                5'd22: r = 32'd163;
                5'd23: r = 32'd81;
                5'd24: r = 32'd41;
                5'd25: r = 32'd20;
                5'd26: r = 32'd10;
                5'd27: r = 32'd5;
                default: r = 32'd0;
            endcase
            return r;
        end
    endfunction

endpackage

### src/ocb_if.sv
// Interface: valid/ready channel carrying one payload item.
interface ocb_if #(parameter type T = logic) (input logic clk);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

### src/ocb_cordic.sv
// Iterative rotation CORDIC: one micro-rotation per cycle, quadrant mapped.
module ocb_cordic (
    input  logic                 clk,
    input  logic                 rst_n,
    input  ocb_pkg::cordic_req_t req,
    output ocb_pkg::cordic_rsp_t rsp
);

    localparam int W = 34;
    localparam int Sh = ocb_pkg::CordicFrac - ocb_pkg::UnitFracBits;
    localparam int UW = ocb_pkg::UnitFracBits + 2;

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [ocb_pkg::StepBits-1:0] step_reg, step_next;
    logic [1:0]           quad_reg, quad_next;
    logic signed [W-1:0]  x_reg, x_next, y_reg, y_next, z_reg, z_next;
    logic signed [UW-1:0] cos_reg, cos_next, sin_reg, sin_next;

    logic [31:0]          u;
    logic signed [W-1:0]  dx, dy, atn, xr, yr;
    logic signed [UW-1:0] c_cl, s_cl;

    assign u = {req.angle, {(32 - ocb_pkg::AngleBits){1'b0}}};

    // Clamp a rounded CORDIC output to [0, one]
    function automatic logic signed [UW-1:0] clamp_unit(input logic signed [W-1:0] v);
        logic signed [W-1:0] r;
        begin
            r = (v + (W'(1) <<< (Sh - 1))) >>> Sh;
            if (r < 0)
                return '0;
            else if (r > W'(ocb_pkg::UnitOne))
                return UW'(ocb_pkg::UnitOne);
            else
                return UW'(r);
        end
    endfunction

    always_comb
    begin
        dx  = y_reg >>> step_reg;
        dy  = x_reg >>> step_reg;
        atn = W'(ocb_pkg::atan_entry(step_reg));
        xr  = x_reg;
        yr  = y_reg;
        c_cl = clamp_unit(x_reg);
        s_cl = clamp_unit(y_reg);
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        quad_next = quad_reg;
        x_next = x_reg;
        y_next = y_reg;
        z_next = z_reg;
        cos_next = cos_reg;
        sin_next = sin_reg;
        if (req.start)
        begin
            // Load start vector and residual angle
            busy_next = 1'b1;
            step_next = '0;
            quad_next = u[31:30];
            x_next = ocb_pkg::CordicGainInv;
            y_next = '0;
            z_next = W'({2'b00, u[29:0]});
        end
        else if (busy_reg)
        begin
            if (step_reg == ocb_pkg::StepBits'(ocb_pkg::CordicSteps))
            begin
                // Round, clamp and rotate into the quadrant
                busy_next = 1'b0;
                done_next = 1'b1;
                case (quad_reg)
                    2'd1:
                    begin
                        cos_next = -s_cl;
                        sin_next = c_cl;
                    end
                    2'd2:
                    begin
                        cos_next = -c_cl;
                        sin_next = -s_cl;
                    end
                    2'd3:
                    begin
                        cos_next = s_cl;
                        sin_next = -c_cl;
                    end
                    default:
                    begin
                        cos_next = c_cl;
                        sin_next = s_cl;
                    end
                endcase
            end
            else
            begin
                if (!z_reg[W-1])
                begin
                    x_next = xr - dx;
                    y_next = yr + dy;
                    z_next = z_reg - atn;
                end
                else
                begin
                    x_next = xr + dx;
                    y_next = yr - dy;
                    z_next = z_reg + atn;
                end
                step_next = step_reg + 1'b1;
            end
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        quad_reg <= quad_next;
        x_reg    <= x_next;
        y_reg    <= y_next;
        z_reg    <= z_next;
        cos_reg  <= cos_next;
        sin_reg  <= sin_next;
    end

    assign rsp.done  = done_reg;
    assign rsp.cos_v = cos_reg;
    assign rsp.sin_v = sin_reg;

endmodule

### src/ocb_regs.sv
// APB configuration registers: target coordinates and distance limits.
module ocb_regs (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output logic signed [23:0] target_x,
    output logic signed [23:0] target_y,
    output logic signed [23:0] target_z,
    output logic [17:0] min_distance,
    output logic [17:0] max_distance
);

    logic signed [23:0] tx_reg, ty_reg, tz_reg;
    logic [17:0] min_reg, max_reg;
    logic        wr;
    logic [2:0]  idx;

    assign pready = 1'b1;
    assign wr  = psel && penable && pwrite;
    assign idx = paddr[4:2];

    // Write on the access phase
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tx_reg  <= '0;
            ty_reg  <= '0;
            tz_reg  <= '0;
            min_reg <= ocb_pkg::MinDistReset;
            max_reg <= ocb_pkg::MaxDistReset;
        end
        else if (wr)
        begin
            case (idx)
                ocb_pkg::RegTargetX: tx_reg  <= pwdata[23:0];
                ocb_pkg::RegTargetY: ty_reg  <= pwdata[23:0];
                ocb_pkg::RegTargetZ: tz_reg  <= pwdata[23:0];
                ocb_pkg::RegMinDist: min_reg <= pwdata[17:0];
                ocb_pkg::RegMaxDist: max_reg <= pwdata[17:0];
                default: ;
            endcase
        end
    end

    // Read back
    always_comb
    begin
        case (idx)
            ocb_pkg::RegTargetX: prdata = {{8{tx_reg[23]}}, tx_reg};
            ocb_pkg::RegTargetY: prdata = {{8{ty_reg[23]}}, ty_reg};
            ocb_pkg::RegTargetZ: prdata = {{8{tz_reg[23]}}, tz_reg};
            ocb_pkg::RegMinDist: prdata = {14'd0, min_reg};
            ocb_pkg::RegMaxDist: prdata = {14'd0, max_reg};
            default:             prdata = '0;
        endcase
    end

    assign target_x = tx_reg;
    assign target_y = ty_reg;
    assign target_z = tz_reg;
    assign min_distance = min_reg;
    assign max_distance = max_reg;

endmodule

### src/orbit_camera_basis_core.sv
// Top level: orbit state update, shared CORDIC and multiplier sequencer.
// Sequence: two CORDIC runs (azimuth, then elevation), each with its result picked
// up, eight multiply steps through one shared multiplier, then the result moves into
// the output register.
// One item is taken at a time; a result still waiting holds the next one.
// Reset: asynchronous, active low; angles clear, distance goes to 10 units,
// targets clear and distance limits return to 0.1 and 1000 units.
module orbit_camera_basis_core (
    input  logic        clk,
    input  logic        rst_n,
    ocb_if.sink         in_ch,
    ocb_if.source       out_ch,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int UF = ocb_pkg::UnitFracBits;
    localparam int UW = UF + 2;
    localparam int AB = ocb_pkg::AngleBits;

    localparam logic [3:0] StIdle = 4'd0;
    localparam logic [3:0] StAz   = 4'd1;
    localparam logic [3:0] StEl   = 4'd2;
    localparam logic [3:0] StM0   = 4'd3;
    localparam logic [3:0] StM1   = 4'd4;
    localparam logic [3:0] StM2   = 4'd5;
    localparam logic [3:0] StM3   = 4'd6;
    localparam logic [3:0] StM4   = 4'd7;
    localparam logic [3:0] StM5   = 4'd8;
    localparam logic [3:0] StM6   = 4'd9;
    localparam logic [3:0] StM7   = 4'd10;
    localparam logic [3:0] StOut  = 4'd11;

    logic signed [23:0] target_x, target_y, target_z;
    logic [17:0] min_distance, max_distance;

    logic [3:0]  state_reg, state_next;
    logic [AB-1:0] az_reg, az_next;
    logic signed [AB-2:0] el_reg, el_next;
    logic [17:0] dist_reg, dist_next;
    logic        ovalid_reg, ovalid_next;
    ocb_pkg::out_item_t obuf_reg, obuf_next;
    ocb_pkg::out_item_t work_reg, work_next;

    logic signed [UW-1:0] ac_reg, ac_next, as_reg, as_next;
    logic signed [UW-1:0] ec_reg, ec_next, es_reg, es_next;
    logic signed [18:0]   ma_reg, ma_next;
    logic signed [31:0]   mb_reg, mb_next;
    logic signed [47:0]   prod_reg;

    ocb_pkg::cordic_req_t creq;
    ocb_pkg::cordic_rsp_t crsp;
    ocb_pkg::in_item_t    in_d;

    logic accept;
    logic signed [20:0] d_ld, d_zm;
    logic signed [AB:0] el_sum;
    logic signed [47:0] prod_r1, prod_r2;
    logic signed [18:0] dist_op;

    ocb_regs u_regs (
        .clk(clk), .rst_n(rst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
        .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .target_x(target_x), .target_y(target_y), .target_z(target_z),
        .min_distance(min_distance), .max_distance(max_distance)
    );

    ocb_cordic u_cordic (
        .clk(clk), .rst_n(rst_n), .req(creq), .rsp(crsp)
    );

    // Clamp low bound first, then high bound
    function automatic logic signed [20:0] clamp_dist(input logic signed [20:0] v,
                                                      input logic [17:0] lo,
                                                      input logic [17:0] hi);
        logic signed [20:0] r;
        begin
            r = v;
            if (r < $signed({3'b000, lo}))
                r = $signed({3'b000, lo});
            if (r > $signed({3'b000, hi}))
                r = $signed({3'b000, hi});
            return r;
        end
    endfunction

    assign in_d   = in_ch.data;
    assign accept = in_ch.valid && in_ch.ready;
    assign in_ch.ready = (state_reg == StIdle);
    assign out_ch.valid = ovalid_reg;
    assign out_ch.data  = obuf_reg;

    assign d_ld = in_d.load_distance
        ? clamp_dist($signed({3'b000, in_d.new_distance}), min_distance, max_distance)
        : $signed({3'b000, dist_reg});
    assign d_zm = clamp_dist(d_ld - 21'(signed'(in_d.zoom_delta)), min_distance,
                             max_distance);
    assign el_sum = (AB+1)'(el_reg) + (AB+1)'(signed'(in_d.delta_elevation));
    assign dist_op = $signed({1'b0, dist_reg});

    // Rounded shifts of the shared product
    assign prod_r1 = (prod_reg + (48'sd1 <<< (UF - 1))) >>> UF;
    assign prod_r2 = (prod_reg + (48'sd1 <<< (2*UF - 1))) >>> (2*UF);

    // Shared multiplier, registered
    always_ff @(posedge clk)
    begin
        prod_reg <= 48'(ma_reg) * 48'(mb_reg);
    end

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        az_next = az_reg;
        el_next = el_reg;
        dist_next = dist_reg;
        ovalid_next = ovalid_reg;
        obuf_next = obuf_reg;
        work_next = work_reg;
        ac_next = ac_reg;
        as_next = as_reg;
        ec_next = ec_reg;
        es_next = es_reg;
        ma_next = ma_reg;
        mb_next = mb_reg;
        creq.start = 1'b0;
        creq.angle = az_reg;
        if (out_ch.valid && out_ch.ready)
            ovalid_next = 1'b0;
        case (state_reg)
            StIdle:
            begin
                if (accept)
                begin
                    // Update orbit state and start the azimuth rotation
                    dist_next = d_zm[17:0];
                    az_next = az_reg + in_d.delta_azimuth[AB-1:0];
                    if (el_sum > (AB+1)'(ocb_pkg::ElevLimit))
                        el_next = (AB-1)'(ocb_pkg::ElevLimit);
                    else if (el_sum < -(AB+1)'(ocb_pkg::ElevLimit))
                        el_next = (AB-1)'(-ocb_pkg::ElevLimit);
                    else
                        el_next = el_sum[AB-2:0];
                    creq.start = 1'b1;
                    creq.angle = az_reg + in_d.delta_azimuth[AB-1:0];
                    state_next = StAz;
                end
            end
            StAz:
            begin
                if (crsp.done)
                begin
                    ac_next = crsp.cos_v;
                    as_next = crsp.sin_v;
                    creq.start = 1'b1;
                    creq.angle = AB'(el_reg);
                    state_next = StEl;
                end
            end
            StEl:
            begin
                if (crsp.done)
                begin
                    ec_next = crsp.cos_v;
                    es_next = crsp.sin_v;
                    work_next.right_x = 16'(ac_reg);
                    work_next.right_y = '0;
                    work_next.right_z = 16'(-as_reg);
                    work_next.forward_y = 16'(-crsp.sin_v);
                    work_next.up_y = 16'(crsp.cos_v);
                    ma_next = 19'(crsp.cos_v);
                    mb_next = 32'(as_reg);
                    state_next = StM0;
                end
            end
            StM0:
            begin
                // ec*ac into multiplier
                ma_next = 19'(ec_reg);
                mb_next = 32'(ac_reg);
                state_next = StM1;
            end
            StM1:
            begin
                // ec*as ready: forward x, then scale by distance
                work_next.forward_x = 16'((-prod_reg + (48'sd1 <<< (UF - 1))) >>> UF);
                ma_next = dist_op;
                mb_next = 32'(prod_reg);
                state_next = StM2;
            end
            StM2:
            begin
                // ec*ac ready: forward z, then scale by distance
                work_next.forward_z = 16'((-prod_reg + (48'sd1 <<< (UF - 1))) >>> UF);
                ma_next = dist_op;
                mb_next = 32'(prod_reg);
                state_next = StM3;
            end
            StM3:
            begin
                // d*ec*as ready
                work_next.position_x = 25'(48'(target_x) + prod_r2);
                ma_next = 19'(es_reg);
                mb_next = 32'(as_reg);
                state_next = StM4;
            end
            StM4:
            begin
                // d*ec*ac ready
                work_next.position_z = 25'(48'(target_z) + prod_r2);
                ma_next = 19'(es_reg);
                mb_next = 32'(ac_reg);
                state_next = StM5;
            end
            StM5:
            begin
                // es*as ready
                work_next.up_x = 16'((-prod_reg + (48'sd1 <<< (UF - 1))) >>> UF);
                ma_next = dist_op;
                mb_next = 32'(es_reg);
                state_next = StM6;
            end
            StM6:
            begin
                // es*ac ready
                work_next.up_z = 16'((-prod_reg + (48'sd1 <<< (UF - 1))) >>> UF);
                state_next = StM7;
            end
            StM7:
            begin
                // d*es ready
                work_next.position_y = 25'(48'(target_y) + prod_r1);
                state_next = StOut;
            end
            StOut:
            begin
                // Hand the item to the output register once it is free
                if (!ovalid_reg || out_ch.ready)
                begin
                    obuf_next = work_reg;
                    ovalid_next = 1'b1;
                    state_next = StIdle;
                end
            end
            default:
            begin
                state_next = StIdle;
            end
        endcase
    end

    // Control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= StIdle;
            az_reg     <= '0;
            el_reg     <= '0;
            dist_reg   <= ocb_pkg::DistReset;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            az_reg     <= az_next;
            el_reg     <= el_next;
            dist_reg   <= dist_next;
            ovalid_reg <= ovalid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        obuf_reg <= obuf_next;
        work_reg <= work_next;
        ac_reg <= ac_next;
        as_reg <= as_next;
        ec_reg <= ec_next;
        es_reg <= es_next;
        ma_reg <= ma_next;
        mb_reg <= mb_next;
    end

    // Checks
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != StIdle) |-> !in_ch.ready)
        else $error("input ready while busy");
    a_elev_range: assert property (@(posedge clk) disable iff (!rst_n)
        ($signed(el_reg) <= (AB-1)'(ocb_pkg::ElevLimit)) &&
        ($signed(el_reg) >= (AB-1)'(-ocb_pkg::ElevLimit)))
        else $error("elevation beyond limit");
    a_out_after_seq: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(ovalid_reg) |-> $past(state_reg) == StOut)
        else $error("result without finished sequence");

endmodule

### tb/sv/orbit_camera_basis_checker.sv
// Checker: watches the orbit event and result channels, predicts and compares results.
module orbit_camera_basis_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_ready,
    input  ocb_pkg::in_item_t  in_data,
    input  logic               out_valid,
    input  logic               out_ready,
    input  ocb_pkg::out_item_t out_data,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_value,
    output int                 fail_count,
    output int                 pending_count
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        longint c;
        longint s;
    } sincos_t;

    localparam longint AtanTable [28] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
        41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20, 10, 5
    };

    ocb_pkg::out_item_t expected_results[$];

    longint tgt_x, tgt_y, tgt_z, dist_lo, dist_hi;
    longint cam_azimuth, cam_elevation, cam_distance;

    // Floor shift and round-half-up shift on signed values
    function automatic longint shr_floor(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint shr_round(longint v, int s);
        return (v + (longint'(1) << (s - 1))) >>> s;
    endfunction

    function automatic longint clamp_range(longint v, longint lo, longint hi);
        if (v < lo)
            v = lo;
        if (v > hi)
            v = hi;
        return v;
    endfunction

    // Rotation CORDIC over one quadrant, then mapped to the angle's quadrant
    function automatic sincos_t angle_sincos(longint angle);
        logic [31:0] u;
        longint x, y, z, dx, dy, t;
        sincos_t r;
        u = 32'(angle & ((longint'(1) << ocb_pkg::AngleBits) - 1))
            << (32 - ocb_pkg::AngleBits);
        z = longint'(u[29:0]);
        x = 652032874;
        y = 0;
        for (int i = 0; i < 28; i++)
        begin
            dx = shr_floor(y, i);
            dy = shr_floor(x, i);
            if (z >= 0)
            begin
                x -= dx;
                y += dy;
                z -= AtanTable[i];
            end
            else
            begin
                x += dx;
                y -= dy;
                z += AtanTable[i];
            end
        end
        r.c = clamp_range(shr_round(x, 16), 0, ocb_pkg::UnitOne);
        r.s = clamp_range(shr_round(y, 16), 0, ocb_pkg::UnitOne);
        case (u[31:30])
            2'd1: begin t = r.c; r.c = -r.s; r.s = t; end
            2'd2: begin r.c = -r.c; r.s = -r.s; end
            2'd3: begin t = r.c; r.c = r.s; r.s = -t; end
            default: ;
        endcase
        return r;
    endfunction

    function automatic ocb_pkg::out_item_t orbit_update(ocb_pkg::in_item_t it);
        sincos_t a, e;
        longint d;
        ocb_pkg::out_item_t r;
        if (it.load_distance)
            cam_distance = clamp_range(longint'(it.new_distance), dist_lo, dist_hi);
        cam_distance = clamp_range(cam_distance - longint'($signed(it.zoom_delta)),
                                   dist_lo, dist_hi);
        cam_azimuth = (cam_azimuth + longint'($signed(it.delta_azimuth)))
                      & ((longint'(1) << ocb_pkg::AngleBits) - 1);
        cam_elevation = clamp_range(cam_elevation + longint'($signed(it.delta_elevation)),
                                    -ocb_pkg::ElevLimit, ocb_pkg::ElevLimit);
        a = angle_sincos(cam_azimuth);
        e = angle_sincos(cam_elevation);
        d = cam_distance;
        r.position_x = 25'(tgt_x + shr_round(d * (e.c * a.s), 28));
        r.position_y = 25'(tgt_y + shr_round(d * e.s, 14));
        r.position_z = 25'(tgt_z + shr_round(d * (e.c * a.c), 28));
        r.forward_x  = 16'(shr_round(-(e.c * a.s), 14));
        r.forward_y  = 16'(-e.s);
        r.forward_z  = 16'(shr_round(-(e.c * a.c), 14));
        r.right_x    = 16'(a.c);
        r.right_y    = '0;
        r.right_z    = 16'(-a.s);
        r.up_x       = 16'(shr_round(-(e.s * a.s), 14));
        r.up_y       = 16'(e.c);
        r.up_z       = 16'(shr_round(-(e.s * a.c), 14));
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("%0t: mismatch %s: got %0h, expected %0h", $time, what, got, want);
        fail_count++;
    endtask

    task automatic compare_result(ocb_pkg::out_item_t got, ocb_pkg::out_item_t want);
        if (got.position_x !== want.position_x)
            report_mismatch("position_x", got.position_x, want.position_x);
        if (got.position_y !== want.position_y)
            report_mismatch("position_y", got.position_y, want.position_y);
        if (got.position_z !== want.position_z)
            report_mismatch("position_z", got.position_z, want.position_z);
        if (got.forward_x !== want.forward_x)
            report_mismatch("forward_x", got.forward_x, want.forward_x);
        if (got.forward_y !== want.forward_y)
            report_mismatch("forward_y", got.forward_y, want.forward_y);
        if (got.forward_z !== want.forward_z)
            report_mismatch("forward_z", got.forward_z, want.forward_z);
        if (got.right_x !== want.right_x)
            report_mismatch("right_x", got.right_x, want.right_x);
        if (got.right_y !== want.right_y)
            report_mismatch("right_y", got.right_y, want.right_y);
        if (got.right_z !== want.right_z)
            report_mismatch("right_z", got.right_z, want.right_z);
        if (got.up_x !== want.up_x)
            report_mismatch("up_x", got.up_x, want.up_x);
        if (got.up_y !== want.up_y)
            report_mismatch("up_y", got.up_y, want.up_y);
        if (got.up_z !== want.up_z)
            report_mismatch("up_z", got.up_z, want.up_z);
    endtask

    assign pending_count = expected_results.size();

    initial
    begin
        fail_count = 0;
    end

    // Track config, predict on accepted events, check accepted results
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tgt_x = 0;
            tgt_y = 0;
            tgt_z = 0;
            dist_lo = longint'(ocb_pkg::MinDistReset);
            dist_hi = longint'(ocb_pkg::MaxDistReset);
            cam_azimuth = 0;
            cam_elevation = 0;
            cam_distance = longint'(ocb_pkg::DistReset);
            expected_results.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    ocb_pkg::RegTargetX: tgt_x = longint'($signed(cfg_value[23:0]));
                    ocb_pkg::RegTargetY: tgt_y = longint'($signed(cfg_value[23:0]));
                    ocb_pkg::RegTargetZ: tgt_z = longint'($signed(cfg_value[23:0]));
                    ocb_pkg::RegMinDist: dist_lo = longint'(cfg_value[17:0]);
                    ocb_pkg::RegMaxDist: dist_hi = longint'(cfg_value[17:0]);
                    default: ;
                endcase
            end
            if (out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                    report_mismatch("result item with no expectation", 0, 0);
                else
                    compare_result(out_data, expected_results.pop_front());
            end
            if (in_valid && in_ready)
                expected_results.push_back(orbit_update(in_data));
        end
    end
endmodule

### tb/sv/orbit_camera_basis_core_tb.sv
// Testbench top: stimulus, config writes, stalls and verdict for the orbit camera core.
module orbit_camera_basis_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int  RandomEvents = 1930;
    localparam longint CycleLimit = 2000000;

    logic        clk;
    logic        rst_n;
    logic        psel, penable, pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    int          fail_count;
    int          pending_count;
    longint      cycle_count;
    bit          hold_off;

    ocb_if #(.T(ocb_pkg::in_item_t))  in_ch (.clk(clk));
    ocb_if #(.T(ocb_pkg::out_item_t)) out_ch (.clk(clk));

    orbit_camera_basis_core uut (
        .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    orbit_camera_basis_checker checker_i (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_data(in_ch.data),
        .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data),
        .cfg_we(psel && penable && pwrite && pready), .cfg_index(paddr[4:2]),
        .cfg_value(pwdata), .fail_count(fail_count), .pending_count(pending_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Mostly short gaps, now and then a long one
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    task automatic reg_write(logic [2:0] index, logic [31:0] value);
        @(negedge clk);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = {index, 2'b00};
        pwdata = value;
        @(negedge clk);
        penable = 1'b1;
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    // Hold until every expected result has come, then let the pipe settle
    task automatic wait_drained();
        @(negedge clk);
        while (pending_count != 0)
            @(negedge clk);
        repeat (100) @(negedge clk);
    endtask

    task automatic send_event(ocb_pkg::in_item_t it, bit with_gap);
        int g;
        g = with_gap ? gap_len() : 0;
        repeat (g) @(negedge clk);
        in_ch.valid = 1'b1;
        in_ch.data = it;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        @(negedge clk);
        in_ch.valid = 1'b0;
    endtask

    function automatic ocb_pkg::in_item_t orbit_event(int da, int de, int zd, bit ld,
                                                      int nd);
        ocb_pkg::in_item_t it;
        it.delta_azimuth = 16'(da);
        it.delta_elevation = 16'(de);
        it.zoom_delta = 19'(zd);
        it.load_distance = ld;
        it.new_distance = 18'(nd);
        return it;
    endfunction

    function automatic ocb_pkg::in_item_t random_event();
        ocb_pkg::in_item_t it;
        int k;
        k = $urandom_range(0, 9);
        it.delta_azimuth = (k < 7) ? 16'($signed($urandom_range(0, 4000)) - 2000)
                                   : 16'($urandom);
        it.delta_elevation = (k < 6) ? 16'($signed($urandom_range(0, 3000)) - 1500)
                                     : 16'($urandom);
        it.zoom_delta = (k < 5) ? 19'($signed($urandom_range(0, 2000)) - 1000)
                                : 19'($urandom);
        it.load_distance = ($urandom_range(0, 5) == 0);
        it.new_distance = 18'($urandom);
        return it;
    endfunction

    task automatic random_phase(int count);
        for (int i = 0; i < count; i++)
            send_event(random_event(), 1'b1);
    endtask

    // Receiver: random stalls plus one long hold-off
    initial
    begin
        out_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_off)
                out_ch.ready = 1'b0;
            else if ($urandom_range(0, 99) < 20)
                out_ch.ready = 1'b0;
            else
                out_ch.ready = 1'b1;
            if (!hold_off && !out_ch.ready && $urandom_range(0, 30) == 0)
                repeat ($urandom_range(20, 200)) @(negedge clk);
        end
    end

    initial
    begin
        hold_off = 1'b0;
        @(posedge rst_n);
        repeat (3000) @(negedge clk);
        hold_off = 1'b1;
        repeat (1500) @(negedge clk);
        hold_off = 1'b0;
    end

    // Cycle limit
    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > CycleLimit)
            begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: reset settings, extremes of every field
        send_event(orbit_event(0, 0, 0, 0, 0), 1'b0);
        send_event(orbit_event(32767, 32767, 0, 0, 0), 1'b0);
        send_event(orbit_event(-32768, -32768, 0, 0, 0), 1'b0);
        send_event(orbit_event(16384, 0, 262143, 0, 0), 1'b0);
        send_event(orbit_event(-16384, 16384, -262144, 0, 0), 1'b0);
        send_event(orbit_event(8192, -16384, 0, 1, 262143), 1'b0);
        send_event(orbit_event(-8192, 100, 0, 1, 0), 1'b0);
        send_event(orbit_event(1, -1, 1, 1, 2560), 1'b0);
        send_event(orbit_event(-1, 16280, -1, 0, 131072), 1'b1);
        send_event(orbit_event(12345, -16280, 300, 1, 65536), 1'b1);
        wait_drained();

        // Extreme targets, zero minimum distance
        reg_write(ocb_pkg::RegTargetX, 32'h007F_FFFF);
        reg_write(ocb_pkg::RegTargetY, 32'h0080_0000);
        reg_write(ocb_pkg::RegTargetZ, 32'h00FF_FFFF);
        reg_write(ocb_pkg::RegMinDist, 32'd0);
        reg_write(ocb_pkg::RegMaxDist, 32'd262143);
        send_event(orbit_event(0, 0, 0, 1, 0), 1'b0);
        send_event(orbit_event(24576, 8000, -262144, 0, 0), 1'b0);
        send_event(orbit_event(-24576, -8000, 0, 1, 262143), 1'b0);
        random_phase(400);
        wait_drained();

        // Minimum above maximum: the maximum wins
        reg_write(ocb_pkg::RegTargetX, 32'hFF80_0000);
        reg_write(ocb_pkg::RegTargetY, 32'h007F_FFFF);
        reg_write(ocb_pkg::RegTargetZ, 32'd0);
        reg_write(ocb_pkg::RegMinDist, 32'd200000);
        reg_write(ocb_pkg::RegMaxDist, 32'd1000);
        send_event(orbit_event(4096, 4096, 5, 1, 50000), 1'b0);
        random_phase(300);
        wait_drained();

        // Narrow limits, smallest legal values
        reg_write(ocb_pkg::RegMinDist, 32'd1);
        reg_write(ocb_pkg::RegMaxDist, 32'd1);
        random_phase(200);
        wait_drained();

        // Typical setting for the long random stretch
        reg_write(ocb_pkg::RegTargetX, 32'd1234);
        reg_write(ocb_pkg::RegTargetY, 32'hFFFF_F000);
        reg_write(ocb_pkg::RegTargetZ, 32'd77777);
        reg_write(ocb_pkg::RegMinDist, 32'd26);
        reg_write(ocb_pkg::RegMaxDist, 32'd256000);
        random_phase(RandomEvents - 900);

        wait_drained();
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule
